// ===== rtl/isqs_pkg.sv =====
package isqs_pkg;

  // request kinds
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_INSERT     = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [2:0] KIND_POP_BACK   = 3'd4;
  localparam logic [2:0] KIND_REMOVE     = 3'd5;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] symbol;
    logic [4:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] length;
    logic [7:0] front_symbol;
    logic [7:0] back_symbol;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

endpackage

// ===== rtl/isqs_ctrl.sv =====
module isqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output isqs_pkg::cmd_t cmd
);
  import isqs_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_ready) state_next = req_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd.exec  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESULT: begin
        rsp_valid = 1'b1;
        req_ready = rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    cmd.load = req_valid & req_ready;
  end

`ifndef NO_ASSERTIONS
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec) else $error("load not followed by execute");
  a_exec_then_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid) else $error("execute not followed by result");
  a_no_load_in_exec: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.exec)) else $error("load during execute");
`endif

endmodule

// ===== rtl/isqs_datapath.sv =====
module isqs_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  isqs_pkg::cmd_t cmd,
  input  isqs_pkg::req_t req,
  output isqs_pkg::rsp_t rsp
);
  import isqs_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > 5) ? CW : 5;

  // captured request
  logic [2:0] kind;
  logic [7:0] symbol;
  logic [4:0] position;

  // cell chain and fill count
  logic [7:0]    cells      [CAPACITY];
  logic [7:0]    cells_next [CAPACITY];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    status;
  logic [1:0]    status_next;

  logic          ins;
  logic          rem;
  logic          full;
  logic [W-1:0]  at;
  logic [W-1:0]  cnt_w;
  logic [W-1:0]  pos_w;
  logic [7:0]    back;

  assign cnt_w = W'(count);
  assign pos_w = W'(position);
  assign full  = (cnt_w == W'(CAPACITY));

  // decode request into one shift operation
  always_comb begin
    ins         = 1'b0;
    rem         = 1'b0;
    at          = '0;
    status_next = ST_ERROR;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ins         = 1'b1;
          status_next = ST_DONE;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ins         = 1'b1;
          at          = cnt_w;
          status_next = ST_DONE;
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_w <= cnt_w) begin
          ins         = 1'b1;
          at          = pos_w;
          status_next = ST_DONE;
        end
      end
      KIND_POP_FRONT: begin
        if (cnt_w != '0) begin
          rem         = 1'b1;
          status_next = ST_DONE;
        end
      end
      KIND_POP_BACK: begin
        if (cnt_w != '0) begin
          rem         = 1'b1;
          at          = cnt_w - W'(1);
          status_next = ST_DONE;
        end
      end
      KIND_REMOVE: begin
        if (pos_w != '0 && pos_w < cnt_w) begin
          rem         = 1'b1;
          at          = pos_w;
          status_next = ST_DONE;
        end
      end
      default: begin
        status_next = ST_ERROR;
      end
    endcase
  end

  // per-cell shift: open a gap to the right or close one from the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cells_next[i] = cells[i];
      if (ins) begin
        if (W'(i) == at) begin
          cells_next[i] = symbol;
        end else if (W'(i) > at) begin
          if (i > 0) cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (rem) begin
        if (W'(i) >= at && i < CAPACITY - 1) begin
          cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ins) begin
      count_next = count + CW'(1);
    end else if (rem) begin
      count_next = count - CW'(1);
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // request capture, cells and status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= req.kind;
      symbol   <= req.symbol;
      position <= req.position;
    end
    if (cmd.exec) begin
      cells  <= cells_next;
      status <= status_next;
    end
  end

  // last entry select
  always_comb begin
    back = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cnt_w == W'(i + 1)) back = back | cells[i];
    end
  end

  // result fields
  assign rsp.status       = status;
  assign rsp.length       = cnt_w[4:0];
  assign rsp.front_symbol = (cnt_w != '0) ? cells[0] : 8'd0;
  assign rsp.back_symbol  = back;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_w <= W'(CAPACITY)) else $error("fill count above capacity");
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status_next != ST_DONE) |=> $stable(count))
    else $error("failed transaction changed the fill count");
  a_done_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status_next == ST_DONE) |=> count != $past(count))
    else $error("completed transaction left the fill count");
`endif

endmodule

// ===== rtl/indexed_sequence_store.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_ready | kind, symbol, position
// rsp     | out       | rsp_valid, rsp_ready | status, length, front_symbol, back_symbol
//
// a transaction is captured on acceptance, executed in the next cycle by a
// chain of byte cells that all shift at once, and held in the result stage
// the next request is taken in the cycle its predecessor's result leaves,
// so a request is never accepted while another is still in flight
// rst is synchronous; it empties the store, cell contents are not cleared
// a stalled result holds the store and blocks new requests
module indexed_sequence_store #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  isqs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output isqs_pkg::rsp_t rsp
);
  import isqs_pkg::*;

  cmd_t cmd;

  isqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  isqs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
